// ----- rtl/core/bpu_pkg.sv -----
package bpu_pkg;

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_16BPP = 3'd3,
    FMT_24BPP = 3'd4,
    FMT_32BPP = 3'd5
  } fmt_e;

  typedef enum logic [2:0] {
    REG_FORMAT  = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_RED     = 3'd2,
    REG_GREEN   = 3'd3,
    REG_BLUE    = 3'd4,
    REG_ENTRIES = 3'd5
  } cfg_reg_e;

  localparam logic       MODE_PAL_WRITE = 1'b0;
  localparam int         NUM_CH         = 3;
  localparam logic [2:0] RST_FORMAT     = 3'd4;
  localparam logic [12:0] RST_WIDTH     = 13'd1;
  localparam logic [15:0] RST_MASK [NUM_CH] = '{16'h7C00, 16'h03E0, 16'h001F};
  localparam logic [3:0]  RST_SHIFT [NUM_CH] = '{4'd10, 4'd5, 4'd0};
  localparam logic [8:0]  RST_MULT      = 9'd8;
  localparam logic [8:0]  RST_ENTRIES   = 9'd256;
  localparam logic [8:0]  SCALE_DIVIDEND = 9'd256;

endpackage

// ----- rtl/core/bpu_ram.sv -----
module bpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bmp_pixel_row_unpacker.sv -----
// Channel  | Direction | Handshake        | Beat
// ---------+-----------+------------------+--------------------------------------------
// in       | sink      | in_valid/stall   | mode, data_byte, palette_index/color
// out      | source    | out_valid/stall  | red, green, blue, alpha, flags
// cfg      | sink      | cfg_valid/ready  | cfg_index, cfg_data
//
// A byte yielding n pixels holds the job register until all n are issued (one pixel
// per cycle while out is not stalled, through the single palette read port). Bytes
// are registered in the job register, pixels in the output register. A mask write
// with a nonzero mask and a span of at most 256 runs a shift-subtract divider for
// the channel scale; input stalls and cfg_ready drops meanwhile. Reset clears row
// state and restores the register defaults. A stall on out holds the output
// register and the job register behind it.
module bmp_pixel_row_unpacker #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_color_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        palette_error_o,
  output logic        row_end_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bpu_pkg::*;

  localparam int WMAX = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int CW   = $clog2(WMAX + 1);
  localparam int PW   = $clog2(4 * WMAX + 1);
  localparam int AW   = $clog2(PALETTE_DEPTH);

  // configuration
  logic [2:0]  format_q;
  logic [12:0] width_q;
  logic [8:0]  entries_q;
  logic [15:0] mask_q  [NUM_CH];
  logic [3:0]  shift_q [NUM_CH];
  logic [8:0]  mult_q  [NUM_CH];

  // scale divider, one per channel
  logic       dbusy_q [NUM_CH];
  logic [8:0] dv_q    [NUM_CH];
  logic [8:0] rem_q   [NUM_CH];
  logic [8:0] quo_q   [NUM_CH];
  logic [3:0] dcnt_q  [NUM_CH];
  logic [8:0] rem_d   [NUM_CH];
  logic [8:0] quo_d   [NUM_CH];
  logic [3:0] ctz_d   [NUM_CH];
  logic [15:0] span_d;
  logic       div_busy;

  // row state
  logic [PW-1:0] pos_q;
  logic [CW-1:0] rpc_q;
  logic [23:0]   partial_q;
  logic [1:0]    phase_q;

  // job register
  logic          job_valid_q;
  logic          job_wr_q;
  fmt_e          job_fmt_q;
  logic [7:0]    job_byte_q;
  logic [31:0]   job_data_q;
  logic [3:0]    job_npix_q;
  logic [2:0]    job_sub_q;
  logic          job_rowend_q;

  // output register
  logic       out_valid_q;
  logic       out_pal_q;
  logic       out_err_q;
  logic       out_rowend_q;
  logic       out_last_q;
  logic [7:0] out_r_q, out_g_q, out_b_q, out_a_q;

  logic [23:0] ram_rdata;

  // ---------------------------------------------------------------- row geometry
  fmt_e          fmt;
  logic [CW-1:0] weff;
  logic [PW-1:0] wx, nbytes, padded;

  always_comb begin
    fmt = (format_q > 3'(FMT_32BPP)) ? FMT_32BPP : fmt_e'(format_q);
    if (width_q == '0) begin
      weff = CW'(1);
    end else if (width_q > 13'(WMAX)) begin
      weff = CW'(WMAX);
    end else begin
      weff = CW'(width_q);
    end
    wx = PW'(weff);
    unique case (fmt)
      FMT_1BPP:  nbytes = (wx + PW'(7)) >> 3;
      FMT_4BPP:  nbytes = (wx + PW'(1)) >> 1;
      FMT_8BPP:  nbytes = wx;
      FMT_16BPP: nbytes = wx << 1;
      FMT_24BPP: nbytes = wx + (wx << 1);
      default:   nbytes = wx << 2;
    endcase
    padded = (nbytes + PW'(3)) & ~PW'(3);
  end

  // ---------------------------------------------------------------- handshakes
  logic out_free, job_emit, job_done, in_accept, cfg_we;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign job_emit   = job_valid_q && !job_wr_q && (job_npix_q != '0) && out_free;
  assign job_done   = job_valid_q && (job_wr_q || (job_npix_q == '0) ||
                      (job_emit && (4'(job_sub_q) + 4'd1 == job_npix_q)));
  assign in_stall_o = (job_valid_q && !job_done) || div_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !div_busy;
  assign cfg_we     = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------- byte intake
  logic          in_row;
  logic [3:0]    nominal, npix;
  logic [CW-1:0] left;
  logic [31:0]   data_d;
  logic [23:0]   partial_d;
  logic [1:0]    phase_d;
  logic          restart;

  always_comb begin
    in_row    = pos_q < nbytes;
    nominal   = 4'd0;
    partial_d = partial_q;
    data_d    = 32'd0;
    unique case (fmt)
      FMT_1BPP: nominal = 4'd8;
      FMT_4BPP: nominal = 4'd2;
      FMT_8BPP: nominal = 4'd1;
      FMT_16BPP: begin
        if (pos_q[0]) begin
          nominal = 4'd1;
          data_d  = {16'd0, data_byte_i, partial_q[7:0]};
        end else begin
          partial_d = {16'd0, data_byte_i};
        end
      end
      default: begin
        if (phase_q == 2'd0) begin
          partial_d = {16'd0, data_byte_i};
        end else if (phase_q == 2'd1) begin
          partial_d = {8'd0, data_byte_i, partial_q[7:0]};
        end else if (phase_q == 2'd2 && fmt == FMT_32BPP) begin
          partial_d = {data_byte_i, partial_q[15:0]};
        end else if (phase_q == 2'd2) begin
          nominal = 4'd1;
          data_d  = {8'd0, data_byte_i, partial_q[15:0]};
        end else begin
          nominal = 4'd1;
          data_d  = {data_byte_i, partial_q};
        end
      end
    endcase
    if (!in_row) begin
      nominal   = 4'd0;
      partial_d = partial_q;
    end
    left = weff - rpc_q;
    npix = (left < CW'(nominal)) ? left[3:0] : nominal;
    if ((fmt == FMT_24BPP && phase_q == 2'd2) || phase_q == 2'd3) begin
      phase_d = 2'd0;
    end else begin
      phase_d = phase_q + 2'd1;
    end
    restart = (pos_q + PW'(1)) >= padded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      rpc_q     <= '0;
      partial_q <= '0;
      phase_q   <= '0;
    end else if (cfg_we && (cfg_index_i == REG_FORMAT || cfg_index_i == REG_WIDTH)) begin
      pos_q     <= '0;
      rpc_q     <= '0;
      partial_q <= '0;
      phase_q   <= '0;
    end else if (in_accept && mode_i != MODE_PAL_WRITE) begin
      if (restart) begin
        pos_q     <= '0;
        rpc_q     <= '0;
        partial_q <= '0;
        phase_q   <= '0;
      end else begin
        pos_q     <= pos_q + PW'(1);
        rpc_q     <= rpc_q + CW'(npix);
        partial_q <= partial_d;
        phase_q   <= phase_d;
      end
    end
  end

  // ---------------------------------------------------------------- job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_sub_q   <= '0;
    end else if (in_accept) begin
      job_valid_q <= 1'b1;
      job_sub_q   <= '0;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
    end else if (job_emit) begin
      job_sub_q <= job_sub_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      job_wr_q     <= (mode_i == MODE_PAL_WRITE);
      job_fmt_q    <= fmt;
      job_npix_q   <= (mode_i == MODE_PAL_WRITE) ? 4'd0 : npix;
      job_rowend_q <= (npix != 4'd0) && (rpc_q + CW'(npix) == weff);
      job_byte_q   <= (mode_i == MODE_PAL_WRITE) ? palette_index_i : data_byte_i;
      job_data_q   <= (mode_i == MODE_PAL_WRITE) ? {8'd0, palette_color_i} : data_d;
    end
  end

  // ---------------------------------------------------------------- pixel issue
  logic [7:0]  idx;
  logic        idx_err, is_indexed, last_pix;
  logic [15:0] px;
  logic [7:0]  fld [NUM_CH];
  logic [7:0]  chv [NUM_CH];
  logic [7:0]  pr_d, pg_d, pb_d, pa_d;

  always_comb begin
    unique case (job_fmt_q)
      FMT_1BPP: idx = {7'd0, job_byte_q[3'd7 - job_sub_q]};
      FMT_4BPP: idx = job_sub_q[0] ? {4'd0, job_byte_q[3:0]} : {4'd0, job_byte_q[7:4]};
      default:  idx = job_byte_q;
    endcase
    is_indexed = (job_fmt_q == FMT_1BPP) || (job_fmt_q == FMT_4BPP) ||
                 (job_fmt_q == FMT_8BPP);
    idx_err    = ({1'b0, idx} >= entries_q) || ({1'b0, idx} >= 9'(PALETTE_DEPTH));
    last_pix   = 4'(job_sub_q) + 4'd1 == job_npix_q;
    px = job_data_q[15:0];
    for (int c = 0; c < NUM_CH; c++) begin
      fld[c] = 8'((px & mask_q[c]) >> shift_q[c]);
      chv[c] = fld[c] * mult_q[c][7:0];
    end
    if (job_fmt_q == FMT_16BPP) begin
      pr_d = chv[0];
      pg_d = chv[1];
      pb_d = chv[2];
      pa_d = 8'd0;
    end else begin
      pr_d = job_data_q[23:16];
      pg_d = job_data_q[15:8];
      pb_d = job_data_q[7:0];
      pa_d = job_data_q[31:24];
    end
    if (is_indexed) begin
      pr_d = 8'd0;
      pg_d = 8'd0;
      pb_d = 8'd0;
      pa_d = 8'd0;
    end
  end

  bpu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (job_valid_q && job_wr_q && (9'(job_byte_q) < 9'(PALETTE_DEPTH))),
    .waddr_i (job_byte_q[AW-1:0]),
    .wdata_i (job_data_q[23:0]),
    .re_i    (job_emit && is_indexed && !idx_err),
    .raddr_i (idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= job_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_emit) begin
      out_pal_q    <= is_indexed && !idx_err;
      out_err_q    <= is_indexed && idx_err;
      out_last_q   <= last_pix;
      out_rowend_q <= last_pix && job_rowend_q;
      out_r_q      <= pr_d;
      out_g_q      <= pg_d;
      out_b_q      <= pb_d;
      out_a_q      <= pa_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = out_pal_q ? ram_rdata[23:16] : out_r_q;
  assign green_o         = out_pal_q ? ram_rdata[15:8]  : out_g_q;
  assign blue_o          = out_pal_q ? ram_rdata[7:0]   : out_b_q;
  assign alpha_o         = out_a_q;
  assign palette_error_o = out_err_q;
  assign row_end_o       = out_rowend_q;
  assign last_of_run_o   = out_last_q;

  // ---------------------------------------------------------------- channel scale
  always_comb begin
    span_d   = '0;
    div_busy = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      ctz_d[c] = 4'd0;
      for (int i = 15; i >= 0; i--) begin
        if (cfg_data_i[i]) begin
          ctz_d[c] = 4'(i);
        end
      end
      div_busy = div_busy || dbusy_q[c];
      // shift in the next dividend bit, subtract when it fits
      rem_d[c] = {rem_q[c][7:0], SCALE_DIVIDEND[dcnt_q[c]]};
      quo_d[c] = {quo_q[c][7:0], 1'b0};
      if (rem_d[c] >= dv_q[c]) begin
        rem_d[c] = rem_d[c] - dv_q[c];
        quo_d[c] = {quo_q[c][7:0], 1'b1};
      end
    end
    span_d = cfg_data_i >> ctz_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q  <= RST_FORMAT;
      width_q   <= RST_WIDTH;
      entries_q <= RST_ENTRIES;
      for (int c = 0; c < NUM_CH; c++) begin
        mask_q[c]  <= RST_MASK[c];
        shift_q[c] <= RST_SHIFT[c];
        mult_q[c]  <= RST_MULT;
        dbusy_q[c] <= 1'b0;
        dcnt_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (dbusy_q[c]) begin
          if (dcnt_q[c] == 4'd0) begin
            dbusy_q[c] <= 1'b0;
            mult_q[c]  <= quo_d[c];
          end else begin
            dcnt_q[c] <= dcnt_q[c] - 4'd1;
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_FORMAT:  format_q  <= cfg_data_i[2:0];
          REG_WIDTH:   width_q   <= cfg_data_i[12:0];
          REG_ENTRIES: entries_q <= cfg_data_i[8:0];
          REG_RED, REG_GREEN, REG_BLUE: begin
            for (int c = 0; c < NUM_CH; c++) begin
              if (cfg_index_i == 3'(int'(REG_RED) + c)) begin
                mask_q[c]  <= cfg_data_i;
                shift_q[c] <= ctz_d[0];
                mult_q[c]  <= '0;
                // spans above 256 scale to zero, so skip the divide
                if (cfg_data_i != '0 && span_d <= 16'd256) begin
                  dbusy_q[c] <= 1'b1;
                  dcnt_q[c]  <= 4'd8;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (cfg_we && !dbusy_q[c] && cfg_index_i == 3'(int'(REG_RED) + c)) begin
        dv_q[c]  <= span_d[8:0];
        rem_q[c] <= '0;
        quo_q[c] <= '0;
      end else if (dbusy_q[c]) begin
        rem_q[c] <= rem_d[c];
        quo_q[c] <= quo_d[c];
      end
    end
  end

endmodule

// ----- rtl/core/bpu_checker.sv -----
module bpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o,
  input logic        palette_error_o,
  input logic        row_end_o,
  input logic        last_of_run_o
);

  // hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(row_end_o) && $stable(last_of_run_o))
    else $error("stalled output beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && palette_error_o |-> red_o == 8'd0 && green_o == 8'd0 &&
      blue_o == 8'd0 && alpha_o == 8'd0)
    else $error("palette error with nonzero color");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> last_of_run_o)
    else $error("row end not on last pixel of its byte");

  // a stalled input beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("stalled input beat withdrawn");

endmodule

bind bmp_pixel_row_unpacker bpu_checker u_bpu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .red_o           (red_o),
  .green_o         (green_o),
  .blue_o          (blue_o),
  .alpha_o         (alpha_o),
  .palette_error_o (palette_error_o),
  .row_end_o       (row_end_o),
  .last_of_run_o   (last_of_run_o)
);

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpu_pkg::*;

  localparam logic MODE_PIXEL = ~MODE_PAL_WRITE;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int PAL_DEPTH = 256;
  localparam int WIDTH_CAP = 4096;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       pal_err;
    logic       row_end;
    logic       last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t      pending[$];
    int          errors;
    int          pixels_seen;
    logic [23:0] palette[PAL_DEPTH];
    logic [2:0]  fmt;
    logic [12:0] width;
    logic [15:0] mask[NUM_CH];
    logic [3:0]  shift[NUM_CH];
    logic [8:0]  mult[NUM_CH];
    logic [8:0]  entries;
    int unsigned byte_pos;
    int unsigned pix_count;
    logic [23:0] partial;
    pixel_t      run[$];

    function new();
      errors = 0;
      pixels_seen = 0;
      fmt = RST_FORMAT;
      width = RST_WIDTH;
      entries = RST_ENTRIES;
      for (int c = 0; c < NUM_CH; c++) begin
        mask[c] = RST_MASK[c];
        derive_scale(c);
      end
      restart();
    endfunction

    function void restart();
      byte_pos = 0;
      pix_count = 0;
      partial = '0;
    endfunction

    function void derive_scale(int c);
      int unsigned s;
      s = 0;
      if (mask[c] == 0) begin
        shift[c] = 0;
        mult[c] = 0;
      end else begin
        while (s < 15 && mask[c][s] == 1'b0) s++;
        shift[c] = s[3:0];
        mult[c] = 9'(256 / (mask[c] >> s));
      end
    endfunction

    function int unsigned row_width();
      if (width == 0) return 1;
      if (width > WIDTH_CAP) return WIDTH_CAP;
      return width;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_FORMAT: begin fmt = val[2:0]; restart(); end
        REG_WIDTH: begin width = val[12:0]; restart(); end
        REG_RED: begin mask[0] = val; derive_scale(0); end
        REG_GREEN: begin mask[1] = val; derive_scale(1); end
        REG_BLUE: begin mask[2] = val; derive_scale(2); end
        REG_ENTRIES: entries = val[8:0];
        default: ;
      endcase
    endfunction

    function void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic err);
      pixel_t px;
      if (run.size() >= 8 || pix_count >= row_width()) return;
      px = '{red: r, green: g, blue: b, alpha: a, pal_err: err,
             row_end: (pix_count + 1 == row_width()), last: 1'b0};
      run = {run, px};
      pix_count++;
    endfunction

    function void lookup(int unsigned idx);
      logic [23:0] col;
      if (idx >= entries || idx >= PAL_DEPTH) begin
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      end else begin
        col = palette[idx];
        push_pixel(col[23:16], col[15:8], col[7:0], 8'd0, 1'b0);
      end
    endfunction

    function void note_beat(logic mode, logic [7:0] data, logic [7:0] pidx, logic [23:0] pcol);
      int unsigned f, w, nbytes, padded, k;
      logic [15:0] pix;
      logic [31:0] chv[NUM_CH];
      if (mode == MODE_PAL_WRITE) begin
        palette[pidx] = pcol;
        return;
      end
      run.delete();
      f = (fmt > FMT_32BPP) ? FMT_32BPP : fmt;
      w = row_width();
      case (f)
        FMT_1BPP: nbytes = (w + 7) / 8;
        FMT_4BPP: nbytes = (w + 1) / 2;
        FMT_8BPP: nbytes = w;
        FMT_16BPP: nbytes = 2 * w;
        FMT_24BPP: nbytes = 3 * w;
        default: nbytes = 4 * w;
      endcase
      padded = (nbytes + 3) & ~32'd3;
      if (byte_pos < nbytes) begin
        case (f)
          FMT_1BPP: for (int i = 7; i >= 0; i--) lookup(data[i]);
          FMT_4BPP: begin
            lookup(data[7:4]);
            lookup(data[3:0]);
          end
          FMT_8BPP: lookup(data);
          FMT_16BPP: begin
            if (byte_pos[0] == 1'b0) begin
              partial = {16'd0, data};
            end else begin
              pix = {data, partial[7:0]};
              for (int c = 0; c < NUM_CH; c++)
                chv[c] = ((pix & mask[c]) >> shift[c]) * mult[c];
              push_pixel(chv[0][7:0], chv[1][7:0], chv[2][7:0], 8'd0, 1'b0);
            end
          end
          default: begin
            k = byte_pos % ((f == FMT_24BPP) ? 3 : 4);
            if (k == 0) partial = {16'd0, data};
            else if (k == 1) partial = {8'd0, data, partial[7:0]};
            else if (k == 2 && f == FMT_32BPP) partial = {data, partial[15:0]};
            else if (k == 2) push_pixel(data, partial[15:8], partial[7:0], 8'd0, 1'b0);
            else push_pixel(partial[23:16], partial[15:8], partial[7:0], data, 1'b0);
          end
        endcase
      end
      byte_pos++;
      if (byte_pos >= padded) restart();
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      pending = {pending, run};
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels_seen++;
      if (pending.size() == 0) begin
        $error("unexpected pixel %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %h actual %h", want.red, got.red); errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %h actual %h", want.green, got.green); errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %h actual %h", want.blue, got.blue); errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha: expected %h actual %h", want.alpha, got.alpha); errors++;
      end
      if (got.pal_err !== want.pal_err) begin
        $error("palette_error: expected %b actual %b", want.pal_err, got.pal_err); errors++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end: expected %b actual %b", want.row_end, got.row_end); errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %b actual %b", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_PIXEL;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  palette_index_i = '0;
  logic [23:0] palette_color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o, green_o, blue_o, alpha_o;
  logic        palette_error_o, row_end_o, last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_left = 0;
  int beats_sent = 0;
  int cfg_writes = 0;

  always #5 clk_i = ~clk_i;

  bmp_pixel_row_unpacker DUT (.*);

  task automatic send_beat(logic mode, logic [7:0] data, logic [7:0] pidx, logic [23:0] pcol);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    data_byte_i <= data;
    palette_index_i <= pidx;
    palette_color_i <= pcol;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(mode, data, pidx, pcol);
    beats_sent++;
  endtask

  task automatic send_byte(logic [7:0] data);
    send_beat(MODE_PIXEL, data, 8'($urandom), 24'($urandom));
  endtask

  // hold the sender until every pixel is out, then give the block time to go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [2:0] fmt, logic [15:0] width, logic [8:0] entries);
    settle();
    write_cfg(REG_FORMAT, {13'd0, fmt});
    write_cfg(REG_WIDTH, width);
    write_cfg(REG_ENTRIES, {7'd0, entries});
  endtask

  task automatic set_masks(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    write_cfg(REG_RED, r);
    write_cfg(REG_GREEN, g);
    write_cfg(REG_BLUE, b);
  endtask

  task automatic random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(MODE_PAL_WRITE, 8'($urandom), 8'($urandom), 24'($urandom));
      else
        send_byte(8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h001F << $urandom_range(0, 11);
      3: return 16'h003F << $urandom_range(0, 10);
      4: return 16'h0001 << $urandom_range(0, 15);
      5: return 16'h00FF << $urandom_range(0, 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall runs, a counted hold-off on request
  initial begin
    int run_left;
    bit run_val;
    int pick;
    run_left = 0;
    run_val = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_pixel('{red: red_o, green: green_o, blue: blue_o, alpha: alpha_o,
                         pal_err: palette_error_o, row_end: row_end_o,
                         last: last_of_run_o});
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 99);
          run_val = (pick >= 65);
          if (pick < 65) run_left = $urandom_range(1, 20);
          else if (pick < 95) run_left = $urandom_range(1, 3);
          else run_left = $urandom_range(20, 60);
        end
        run_left--;
        out_stall_i <= run_val;
      end
    end
  end

  initial begin
    #20ms;
    $display("bmp_pixel_row_unpacker test failed");
    $finish;
  end

  initial begin
    int phases;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: 24bpp, one pixel per row, one pad byte
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A); send_byte(8'hA5);

    // fill the whole palette so no lookup reads an unwritten entry
    for (int i = 0; i < PAL_DEPTH; i++)
      send_beat(MODE_PAL_WRITE, 8'(i), 8'(i), 24'($urandom));

    setup(FMT_1BPP, 16'd9, 9'd1);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h3C);
    setup(FMT_4BPP, 16'd3, 9'd0);
    send_byte(8'h0F); send_byte(8'hF0); send_byte(8'h12); send_byte(8'h34);
    setup(FMT_8BPP, 16'd0, 9'd256);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'h01);
    setup(FMT_16BPP, 16'd1, 9'd255);
    set_masks(16'hFFFF, 16'h0000, 16'h0180);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h80); send_byte(8'h01);
    settle();
    set_masks(16'hF800, 16'h07E0, 16'h001F);
    send_byte(8'h34); send_byte(8'h12); send_byte(8'h00); send_byte(8'h80);
    setup(3'd7, 16'd1, 9'd256);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
    setup(3'd6, 16'hFFFF, 9'd256);
    write_cfg(REG_SPARE_LO, 16'hFFFF);
    write_cfg(REG_SPARE_HI, 16'h0000);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);

    // hold the receiver while the sender streams 1bpp bytes and palette writes back to back
    setup(FMT_1BPP, 16'd16, 9'd2);
    quiet = 1'b1;
    hold_left = 300;
    random_stream(24);
    quiet = 1'b0;

    phases = 0;
    while (beats_sent < 360) begin
      setup(3'($urandom_range(0, 7)),
            ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8191))
                                        : 16'($urandom_range(0, 12)),
            ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 256)) : 9'd256);
      if ($urandom_range(0, 1) == 1) set_masks(pick_mask(), pick_mask(), pick_mask());
      quiet = ($urandom_range(0, 5) == 0);
      random_stream($urandom_range(8, 40));
      quiet = 1'b0;
      phases++;
    end
    settle();

    $display("sent %0d beats over %0d random phases, %0d register writes", beats_sent,
             phases, cfg_writes);
    $display("checked %0d pixels across all six formats and the alias codes",
             sb.pixels_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bmp_pixel_row_unpacker test passed");
    end else begin
      $display("bmp_pixel_row_unpacker test failed");
    end
    $finish;
  end
endmodule
